// File: src/rwsr_pkg.sv
// ----------------------------------------------------------------------------
// rwsr_pkg : shared definitions for the rolling window spike ratio unit
// Widths, limits, register map and the divider command/status records.
// ----------------------------------------------------------------------------
package rwsr_pkg;

  localparam int NUM_BUCKETS = 10;

  localparam int CNT_W     = 16;
  localparam int TICK_W    = 63;
  localparam int CFG_W     = 32;
  localparam int ADDR_W    = 3;
  localparam int TOTAL_W   = 20;
  localparam int RATIO_W   = 14;

  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam int SUM_W  = $clog2(NUM_BUCKETS * 65535 + 1);
  localparam int SLOT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  localparam int RATIO_SCALE = 10000;
  localparam int PROD_W      = SUM_W + RATIO_W;

  // shared restoring divider
  localparam int DVD_W  = 64;
  localparam int DVS_W  = 32;
  localparam int STEP_W = 7;

  localparam logic [CFG_W-1:0] BUCKET_CYCLES_RESET = 32'd100000;

  // register index, taken from paddr[2]
  localparam logic REG_BUCKET_CYCLES = 1'b0;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;   // left aligned, MSB consumed first
    logic [DVS_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic step;   // a quotient bit is produced this cycle
    logic qbit;
    logic done;   // last step this cycle
  } div_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_total(input logic [SUM_W-1:0] v);
    sat_total = (32'(v) > 32'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(v);
  endfunction

endpackage

// File: src/rwsr_div.sv
// ----------------------------------------------------------------------------
// rwsr_div : shared bit-serial restoring divider
// One quotient bit per cycle, MSB first, for a programmable number of steps.
// ----------------------------------------------------------------------------
module rwsr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rwsr_pkg::div_cmd_t           cmd_i,
  output rwsr_pkg::div_stat_t          stat_o,
  output logic [rwsr_pkg::DVD_W-1:0]   quotient_o
);
  import rwsr_pkg::*;

  logic              busy_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              qbit;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = (trial >= {1'b0, dvs_q});
  assign rem_d = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= cmd_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dvd_q <= cmd_i.dividend;
      dvs_q <= cmd_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[DVD_W-2:0], qbit};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.step = busy_q;
  assign stat_o.qbit = qbit;
  assign stat_o.done = busy_q && (cnt_q == STEP_W'(1));
  assign quotient_o  = quo_q;

`ifndef NO_ASSERTIONS
  // never restart the unit in the middle of a division
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q)
    else $error("divider started while busy");

  // the unit goes idle right after its last step
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_o.done && !cmd_i.start) |=> !busy_q)
    else $error("divider still busy after last step");

  // a running division always has steps left
  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("divider busy with no steps left");
`endif

endmodule

// File: src/rolling_window_spike_ratio_unit.sv
// ----------------------------------------------------------------------------
// rolling_window_spike_ratio_unit : bucketed sliding-window spike ratio
// Sorts each sample into a time bucket, keeps saturating per-slot frame and
// spike counts, and reports window totals plus the spike share in 0.01 %.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-----------------------------------
//  s_axis   | in  | tvalid / tready        | tdata: now_ticks, tuser: spike
//  m_axis   | out | tvalid / tready        | tdata: frame/spike totals, ratio
//  apb      | in  | psel/penable/pready    | bucket_cycles at byte address 0
//
//  Each sample passes through the bucket division, the slot update, the
//  summation over all NUM_BUCKETS slots, the product and the ratio division
//  before the next sample is taken. Both divisions run on the one shared
//  bit-serial divider, one quotient bit per cycle.
//  Reset clears the counters and the current bucket and sets bucket_cycles to 100000.
//  s_axis_tready is high only while the sequencer is idle; a finished result
//  waits in the output register and the next sample is taken meanwhile; while
//  that register is still full the sequencer holds in its done state.
//
module rolling_window_spike_ratio_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [63:0]                  s_axis_tdata,  // [62:0] now_ticks, [63] zero
  input  logic [0:0]                   s_axis_tuser,  // [0] spike

  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [55:0]                  m_axis_tdata,  // [19:0] frame_total,
                                                      // [39:20] spike_total,
                                                      // [53:40] spike_ratio, zero pad

  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rwsr_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import rwsr_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV1   = 3'd1;
  localparam logic [2:0] S_UPD    = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_DIV2GO = 3'd5;
  localparam logic [2:0] S_DIV2   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]        state_q, state_d;

  logic [CFG_W-1:0]  bucket_cycles_q;
  logic [CFG_W-1:0]  width;

  logic [CNT_W-1:0]  frame_q [NUM_BUCKETS];
  logic [CNT_W-1:0]  spike_q [NUM_BUCKETS];
  logic [TICK_W-1:0] cur_bucket_q;

  logic              spike_in_q;
  logic [SLOT_W-1:0] slot_q;       // bucket mod NUM_BUCKETS, folded during division
  logic [SLOT_W:0]   fold;
  logic [SLOT_W-1:0] idx_q;
  logic [SLOT_W-1:0] rd_idx;
  logic [CNT_W-1:0]  rd_frame, rd_spike;

  logic [SUM_W-1:0]  f_acc_q, s_acc_q;
  logic [PROD_W-1:0] prod_q;

  logic [55:0]       out_data_q;
  logic              out_valid_q;

  div_cmd_t          div_cmd;
  div_stat_t         div_stat;
  logic [DVD_W-1:0]  div_quo;

  logic              in_xfer;
  logic              out_free;
  logic [TICK_W-1:0] bucket;
  logic              new_bucket;
  logic [CNT_W-1:0]  base_frame, base_spike, upd_frame, upd_spike;
  logic [RATIO_W-1:0] ratio;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUCKET_CYCLES) ? bucket_cycles_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_cycles_q <= BUCKET_CYCLES_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BUCKET_CYCLES)) begin
      bucket_cycles_q <= pwdata;
    end
  end

  // a zero bucket width acts as one tick
  assign width = (bucket_cycles_q == '0) ? CFG_W'(1) : bucket_cycles_q;

  // ---------------------------------------------------------------- handshakes
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------- divider
  // first pass: now_ticks / width; second pass: 10000*S / F
  always_comb begin
    div_cmd = '0;
    if (in_xfer) begin
      div_cmd.start    = 1'b1;
      div_cmd.dividend = {s_axis_tdata[TICK_W-1:0], {(DVD_W-TICK_W){1'b0}}};
      div_cmd.divisor  = width;
      div_cmd.steps    = STEP_W'(TICK_W);
    end else if (state_q == S_DIV2GO) begin
      div_cmd.start    = 1'b1;
      div_cmd.dividend = {prod_q, {(DVD_W-PROD_W){1'b0}}};
      div_cmd.divisor  = DVS_W'(f_acc_q);
      div_cmd.steps    = STEP_W'(PROD_W);
    end
  end

  rwsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (div_cmd),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // fold quotient bits, MSB first, into the slot: m = (2m + q) mod N
  always_comb begin
    fold = {slot_q, div_stat.qbit};
    if (32'(fold) >= 32'(NUM_BUCKETS)) begin
      fold = fold - (SLOT_W+1)'(NUM_BUCKETS);
    end
  end

  // ---------------------------------------------------------------- slot update
  assign bucket     = div_quo[TICK_W-1:0];
  assign rd_idx     = (state_q == S_UPD) ? slot_q : idx_q;
  assign rd_frame   = frame_q[rd_idx];
  assign rd_spike   = spike_q[rd_idx];
  assign new_bucket = (bucket != cur_bucket_q);
  assign base_frame = new_bucket ? '0 : rd_frame;
  assign base_spike = new_bucket ? '0 : rd_spike;
  assign upd_frame  = sat_inc(base_frame);
  // a spike count never passes its slot's frame count
  assign upd_spike  = (spike_in_q && (base_spike < upd_frame)) ? sat_inc(base_spike)
                                                               : base_spike;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_bucket_q <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        frame_q[i] <= '0;
        spike_q[i] <= '0;
      end
    end else if (state_q == S_UPD) begin
      cur_bucket_q    <= bucket;
      frame_q[slot_q] <= upd_frame;
      spike_q[slot_q] <= upd_spike;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_xfer) state_d = S_DIV1;
      S_DIV1:   if (div_stat.done) state_d = S_UPD;
      S_UPD:    state_d = S_SUM;
      S_SUM:    if (idx_q == SLOT_W'(NUM_BUCKETS-1)) state_d = S_MUL;
      S_MUL:    state_d = S_DIV2GO;
      S_DIV2GO: state_d = S_DIV2;
      S_DIV2:   if (div_stat.done) state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign ratio = (f_acc_q == '0) ? '0 : div_quo[RATIO_W-1:0];

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      spike_in_q <= s_axis_tuser[0];
      slot_q     <= '0;
    end else if (state_q == S_DIV1 && div_stat.step) begin
      slot_q <= fold[SLOT_W-1:0];
    end

    if (state_q == S_UPD) begin
      idx_q   <= '0;
      f_acc_q <= '0;
      s_acc_q <= '0;
    end else if (state_q == S_SUM) begin
      idx_q   <= idx_q + SLOT_W'(1);
      f_acc_q <= f_acc_q + SUM_W'(rd_frame);
      s_acc_q <= s_acc_q + SUM_W'(rd_spike);
    end

    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(s_acc_q) * PROD_W'(RATIO_SCALE);
    end

    if (state_q == S_DONE && out_free) begin
      out_data_q <= {2'b00, ratio, sat_total(s_acc_q), sat_total(f_acc_q)};
    end
  end

`ifndef NO_ASSERTIONS
  // a transferred sample keeps the input closed on the following cycle
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("input reopened right after a transfer");

  // the folded slot stays inside the window
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (32'(slot_q) < 32'(NUM_BUCKETS)))
    else $error("slot index out of range");

  // spike sum never passes the frame sum
  a_sum_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (s_acc_q <= f_acc_q))
    else $error("spike total above frame total");

  // reported ratio stays within 100.00 percent
  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[53:40] <= 14'd10000))
    else $error("ratio above 10000");
`endif

endmodule

// File: tb/sv/rolling_window_spike_ratio_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rolling_window_spike_ratio_unit_tb : self-checking bench for the spike ratio unit
// Streams timestamped samples through the unit while both stream sides stall
// at random. Each result is checked against a local model of the bucket
// counters. The model covers slot clearing, a zero bucket width, the
// out-of-range register index and the spike share in 0.01 %.
// ----------------------------------------------------------------------------
module rolling_window_spike_ratio_unit_tb;
  import rwsr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 10_000_000;
  localparam int          TAIL_CYCLES  = 250;
  localparam int          REPORT_LIMIT = 10;
  localparam int          PHASES       = 14;
  localparam int          PHASE_ITEMS  = 125;

  // Byte addresses: the register index sits in paddr[2].
  localparam logic [ADDR_W-1:0] BUCKET_CYCLES_ADDR = {REG_BUCKET_CYCLES, 2'b00};
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR      = {~REG_BUCKET_CYCLES, 2'b00};

  localparam logic [TICK_W-1:0] TICK_TOP  = {TICK_W{1'b1}};
  localparam logic [TICK_W-1:0] TICK_ALT  = 63'h2AAA_AAAA_AAAA_AAAA;

  // One result transfer: window totals and spike share.
  typedef struct packed {
    logic [TOTAL_W-1:0] frame_total;
    logic [TOTAL_W-1:0] spike_total;
    logic [RATIO_W-1:0] ratio;
  } window_stats_t;

  // One step of the directed sequence: a register write or a sample.
  typedef struct packed {
    logic                is_reg;
    logic [ADDR_W-1:0]   addr;
    logic [CFG_W-1:0]    value;
    logic                spike;
    logic [TICK_W-1:0]   now;
    logic                typed;    // expected result is given in the row
    window_stats_t       want;
  } directed_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata;   // [62:0] now_ticks, [63] zero
  logic [0:0]   s_axis_tuser;   // [0] spike
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [55:0]  m_axis_tdata;   // [19:0] frame_total, [39:20] spike_total,
                                // [53:40] spike_ratio, [55:54] zero
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  // Model state of the window, mirrored from the unit's behavior.
  logic [CNT_W-1:0]  slot_frames [NUM_BUCKETS];
  logic [CNT_W-1:0]  slot_spikes [NUM_BUCKETS];
  logic [TICK_W-1:0] open_bucket;
  logic [CFG_W-1:0]  ticks_per_bucket;

  window_stats_t     expected_stats_q [$];
  directed_row_t     directed_plan [$];

  int unsigned cycle_count;
  int          mismatch_count;
  int          samples_sent;
  int          results_checked;
  int          widths_applied;
  int          rx_hold;
  bit          rx_idle_on;
  int unsigned peak_frames;
  int unsigned min_share;
  int unsigned max_share;

  rolling_window_spike_ratio_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Window model
  // --------------------------------------------------------------------------

  // Return the model to its post-reset state.
  function automatic void clear_window();
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      slot_frames[i] = '0;
      slot_spikes[i] = '0;
    end
    open_bucket      = '0;
    ticks_per_bucket = BUCKET_CYCLES_RESET;
  endfunction

  // Sort one sample into its bucket, bump the slot and report the window.
  function automatic window_stats_t predict_window(input logic spike,
                                                   input logic [TICK_W-1:0] now);
    logic [63:0]     width;
    logic [63:0]     bkt;
    int              idx;
    longint unsigned f_sum;
    longint unsigned s_sum;
    longint unsigned share;
    window_stats_t   res;
    // A zero width behaves as one tick per bucket.
    width = (ticks_per_bucket == '0) ? 64'd1 : 64'(ticks_per_bucket);
    bkt   = 64'(now) / width;
    idx   = int'(bkt % 64'(NUM_BUCKETS));
    // Entering another bucket recycles its slot; skipped slots keep their counts.
    if (bkt[TICK_W-1:0] != open_bucket) begin
      slot_frames[idx] = '0;
      slot_spikes[idx] = '0;
      open_bucket      = bkt[TICK_W-1:0];
    end
    if (slot_frames[idx] != CNT_MAX) slot_frames[idx] = slot_frames[idx] + CNT_W'(1);
    if (spike && slot_spikes[idx] < slot_frames[idx]) begin
      slot_spikes[idx] = slot_spikes[idx] + CNT_W'(1);
    end
    f_sum = 0;
    s_sum = 0;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      f_sum += slot_frames[i];
      s_sum += slot_spikes[i];
    end
    share = (f_sum == 0) ? 0 : (64'd10000 * s_sum) / f_sum;
    res.frame_total = (f_sum > TOTAL_MAX) ? TOTAL_MAX : f_sum[TOTAL_W-1:0];
    res.spike_total = (s_sum > TOTAL_MAX) ? TOTAL_MAX : s_sum[TOTAL_W-1:0];
    res.ratio       = share[RATIO_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  function automatic window_stats_t stats(input int unsigned f, input int unsigned s,
                                          input int unsigned r);
    window_stats_t res;
    res.frame_total = f[TOTAL_W-1:0];
    res.spike_total = s[TOTAL_W-1:0];
    res.ratio       = r[RATIO_W-1:0];
    return res;
  endfunction

  function automatic directed_row_t sample_row(input logic spike,
                                               input logic [TICK_W-1:0] now,
                                               input logic typed,
                                               input window_stats_t want);
    directed_row_t row;
    row        = '0;
    row.spike  = spike;
    row.now    = now;
    row.typed  = typed;
    row.want   = want;
    return row;
  endfunction

  function automatic directed_row_t reg_row(input logic [ADDR_W-1:0] addr,
                                            input logic [CFG_W-1:0] value);
    directed_row_t row;
    row        = '0;
    row.is_reg = 1'b1;
    row.addr   = addr;
    row.value  = value;
    return row;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 24);
    return $urandom_range(60, 300);
  endfunction

  function automatic void flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, what);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      flag_mismatch($sformatf("result %0d: %s expected %0d, got %0d",
                              results_checked, name, want, got));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus side: samples on the slave stream, register accesses on APB
  // --------------------------------------------------------------------------

  // Present one sample and hold it until the transfer; then queue its result.
  task automatic push_sample(input logic spike, input logic [TICK_W-1:0] now,
                             input logic typed, input window_stats_t want);
    window_stats_t calc;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, now};
    s_axis_tuser  <= spike;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    calc = predict_window(spike, now);
    expected_stats_q.push_back(typed ? want : calc);
    samples_sent++;
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Drop valid and hold off until every queued result has been taken.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_stats_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    // Only index 0 holds a register; other indexes are ignored.
    if (addr[2] == REG_BUCKET_CYCLES) begin
      ticks_per_bucket = value;
      widths_applied++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Read the width back and compare with the model's copy.
  task automatic verify_width_reg();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= BUCKET_CYCLES_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata != ticks_per_bucket) begin
      flag_mismatch($sformatf("bucket_cycles read expected %0d, got %0d",
                              ticks_per_bucket, prdata));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_width(input logic [CFG_W-1:0] value);
    drain_results();
    apb_write(BUCKET_CYCLES_ADDR, value);
    verify_width_reg();
  endtask

  // One random phase: a timestamp that mostly creeps forward inside and across
  // buckets, with skips, rewinds and wild jumps mixed in.
  task automatic run_random_phase(input int count, input logic [CFG_W-1:0] width);
    logic [TICK_W-1:0] tick;
    logic [63:0]       span;
    logic [63:0]       hop;
    int                roll;
    int                spike_pct;
    bit                tx_idle;
    set_width(width);
    span      = (width == '0) ? 64'd1 : 64'(width);
    tick      = $urandom_range(0, 1) ? TICK_W'({$urandom, $urandom}) : TICK_W'($urandom);
    spike_pct = $urandom_range(0, 100);
    tx_idle   = ($urandom_range(0, 3) != 0);
    rx_idle_on = ($urandom_range(0, 3) != 0);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 82) begin
        // stay in the bucket or step into the next one
        hop  = {$urandom, $urandom} % (span / 2 + 2);
        tick = tick + TICK_W'(hop);
      end else if (roll < 92) begin
        // skip over several buckets, leaving their slots stale
        hop  = span * 64'($urandom_range(2, 3 * NUM_BUCKETS));
        tick = tick + TICK_W'(hop);
      end else if (roll < 96) begin
        tick = TICK_W'({$urandom, $urandom});
      end else begin
        hop  = span * 64'($urandom_range(1, NUM_BUCKETS));
        tick = tick - TICK_W'(hop);
      end
      push_sample($urandom_range(0, 99) < spike_pct, tick, 1'b0, '0);
      if (tx_idle && $urandom_range(0, 1) == 1) idle_sender(pick_gap());
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the checker
  // --------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
      rx_hold       <= pick_gap() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    window_stats_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_stats_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: frames %0d spikes %0d share %0d",
                                m_axis_tdata[19:0], m_axis_tdata[39:20],
                                m_axis_tdata[53:40]));
      end else begin
        want = expected_stats_q.pop_front();
        check_field("frame_total", want.frame_total, m_axis_tdata[19:0]);
        check_field("spike_total", want.spike_total, m_axis_tdata[39:20]);
        check_field("spike_ratio", want.ratio, m_axis_tdata[53:40]);
        if (want.frame_total > peak_frames) peak_frames = want.frame_total;
        if (want.ratio < min_share) min_share = want.ratio;
        if (want.ratio > max_share) max_share = want.ratio;
        results_checked++;
      end
    end
  end

  // Hard stop if the unit hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_stats_q.size());
      $display("[rolling_window_spike_ratio_unit] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    directed_row_t row;
    logic [CFG_W-1:0] width;

    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    m_axis_tready   = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    cycle_count     = 0;
    mismatch_count  = 0;
    samples_sent    = 0;
    results_checked = 0;
    widths_applied  = 0;
    rx_hold         = 0;
    rx_idle_on      = 1'b1;
    peak_frames     = 0;
    min_share       = 10000;
    max_share       = 0;
    clear_window();

    // Directed part. Rows after reset (width 100000) carry hand-worked results:
    // the first sample lands in bucket 0 without a clear, the top timestamp
    // lands in slot 7.
    directed_plan.push_back(sample_row(1'b0, '0,           1'b1, stats(1, 0, 0)));
    directed_plan.push_back(sample_row(1'b1, 63'd99999,    1'b1, stats(2, 1, 5000)));
    directed_plan.push_back(sample_row(1'b1, 63'd100000,   1'b1, stats(3, 2, 6666)));
    directed_plan.push_back(sample_row(1'b1, TICK_TOP,     1'b1, stats(4, 3, 7500)));
    directed_plan.push_back(sample_row(1'b0, '0,           1'b0, '0));
    directed_plan.push_back(sample_row(1'b1, TICK_ALT,     1'b0, '0));
    directed_plan.push_back(sample_row(1'b1, ~TICK_ALT,    1'b0, '0));
    // write to the unmapped index must leave the width alone
    directed_plan.push_back(reg_row(UNMAPPED_ADDR, 32'd7));
    directed_plan.push_back(sample_row(1'b1, 63'd200000,   1'b0, '0));
    // zero width acts as one tick per bucket
    directed_plan.push_back(reg_row(BUCKET_CYCLES_ADDR, '0));
    directed_plan.push_back(sample_row(1'b1, 63'd5,        1'b0, '0));
    directed_plan.push_back(sample_row(1'b1, 63'd5,        1'b0, '0));
    directed_plan.push_back(sample_row(1'b0, 63'd6,        1'b0, '0));
    directed_plan.push_back(sample_row(1'b1, TICK_TOP,     1'b0, '0));
    // widest bucket
    directed_plan.push_back(reg_row(BUCKET_CYCLES_ADDR, {CFG_W{1'b1}}));
    directed_plan.push_back(sample_row(1'b0, '0,           1'b0, '0));
    directed_plan.push_back(sample_row(1'b1, 63'hFFFF_FFFE, 1'b0, '0));
    directed_plan.push_back(sample_row(1'b1, 63'hFFFF_FFFF, 1'b0, '0));
    directed_plan.push_back(sample_row(1'b1, TICK_TOP,     1'b0, '0));
    // one-tick buckets: slot 0 is recycled when bucket 20 replaces bucket 10
    directed_plan.push_back(reg_row(BUCKET_CYCLES_ADDR, 32'd1));
    directed_plan.push_back(sample_row(1'b1, 63'd10,       1'b0, '0));
    directed_plan.push_back(sample_row(1'b1, 63'd20,       1'b0, '0));

    // Hold reset, then release it away from the clock edge.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    verify_width_reg();

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.is_reg) begin
        drain_results();
        apb_write(row.addr, row.value);
        verify_width_reg();
      end else begin
        push_sample(row.spike, row.now, row.typed, row.want);
        if ($urandom_range(0, 2) == 0) idle_sender(pick_gap());
      end
    end

    // Random phases, cycling through the extreme widths and a few random ones.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 7)
        0:       width = 32'd1;
        1:       width = {CFG_W{1'b1}};
        2:       width = '0;
        3:       width = $urandom_range(2, 40);
        4:       width = $urandom_range(100, 5000);
        5:       width = BUCKET_CYCLES_RESET;
        default: width = $urandom;
      endcase
      if ($urandom_range(0, 2) == 0) begin
        drain_results();
        apb_write(UNMAPPED_ADDR, $urandom);
      end
      run_random_phase(PHASE_ITEMS, width);
    end

    // Wait for the last results, then give stray transfers time to show up.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d samples over %0d bucket width settings, %0d results checked",
             samples_sent, widths_applied, results_checked);
    $display("largest window frame total %0d, spike share seen from %0d to %0d",
             peak_frames, min_share, max_share);
    if (mismatch_count == 0 && expected_stats_q.size() == 0) begin
      $display("[rolling_window_spike_ratio_unit] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               expected_stats_q.size());
      $display("[rolling_window_spike_ratio_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
src/rwsr_pkg.sv
src/rwsr_div.sv
src/rolling_window_spike_ratio_unit.sv
tb/sv/rolling_window_spike_ratio_unit_tb.sv
